>>> src/etf_pkg.sv
// Package for the escape-time fractal iterator.
// Holds the channel payload types, register indexes, reset values and default widths.
// No dependencies.
`default_nettype none

package etf_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int INT_BITS        = 4;

	localparam int IN_W      = 32;
	localparam int LIMIT_W   = 16;
	localparam int STEP_W    = 16;
	localparam int COLOR_W   = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	localparam int JOB_DEPTH = 2;
	localparam int RES_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_JULIA_RE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_JULIA_IM = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 2'd3;

	localparam logic                   MODE_MANDEL  = 1'b0;
	localparam logic                   MODE_JULIA   = 1'b1;
	localparam logic signed [IN_W-1:0] RST_JULIA_RE = -32'sd41070625;
	localparam logic signed [IN_W-1:0] RST_JULIA_IM = 32'sd175287011;
	localparam logic [LIMIT_W-1:0]     RST_LIMIT    = 16'd10000;

	typedef struct packed {
		logic signed [IN_W-1:0] point_re;
		logic signed [IN_W-1:0] point_im;
	} point_t;

	typedef struct packed {
		logic [COLOR_W-1:0] color_index;
		logic               escaped;
		logic [STEP_W-1:0]  step_count;
	} res_t;

endpackage

`default_nettype wire

>>> src/etf_fifo.sv
// Small first-in first-out queue built from flip-flops.
// Generic in width and depth; used for the job queue and the result queue.
// No package dependencies.
`default_nettype none

module etf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [NW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == NW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/etf_front.sv
// Front part of the fractal iterator: configuration registers and job setup.
// Saturates the point, picks the constant by mode, clamps the limit; uses etf_pkg.
`default_nettype none

module etf_front #(
	parameter int COORD_WIDTH = etf_pkg::COORD_WIDTH_DEF,
	parameter int COUNT_WIDTH = etf_pkg::COUNT_WIDTH_DEF,
	parameter int JOB_W       = 4 * COORD_WIDTH + COUNT_WIDTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	input  wire logic                            job_full,
	input  wire etf_pkg::point_t                 point,
	input  wire logic                            cfg_wr_en,
	input  wire logic [etf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [etf_pkg::CFG_DAT_W-1:0]   cfg_data,
	output logic                                 job_push,
	output logic      [JOB_W-1:0]                job
);

	localparam int CW  = COORD_WIDTH;
	localparam int NW  = COUNT_WIDTH;
	localparam int EW  = (CW > etf_pkg::IN_W) ? CW : etf_pkg::IN_W;
	localparam int LW  = (NW > etf_pkg::LIMIT_W) ? NW : etf_pkg::LIMIT_W;

	logic                                mode_q;
	logic signed [etf_pkg::IN_W-1:0]     jre_q;
	logic signed [etf_pkg::IN_W-1:0]     jim_q;
	logic [etf_pkg::LIMIT_W-1:0]         limit_q;

	logic signed [CW-1:0] pr;
	logic signed [CW-1:0] pi;
	logic signed [CW-1:0] cr;
	logic signed [CW-1:0] ci;
	logic [LW-1:0]        lim_ext;
	logic [LW-1:0]        cmax_ext;
	logic [NW-1:0]        lim;

	function automatic logic signed [CW-1:0] sat_in(input logic signed [etf_pkg::IN_W-1:0] v);
		logic signed [EW-1:0] e;
		logic [EW-CW:0]       upper;
		e     = EW'(v);
		upper = e[EW-1:CW-1];
		if ((&upper) || !(|upper)) begin
			return e[CW-1:0];
		end else if (e[EW-1]) begin
			return {1'b1, {(CW - 1){1'b0}}};
		end else begin
			return {1'b0, {(CW - 1){1'b1}}};
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= etf_pkg::MODE_MANDEL;
			jre_q   <= etf_pkg::RST_JULIA_RE;
			jim_q   <= etf_pkg::RST_JULIA_IM;
			limit_q <= etf_pkg::RST_LIMIT;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				etf_pkg::REG_MODE:     mode_q  <= cfg_data[0];
				etf_pkg::REG_JULIA_RE: jre_q   <= cfg_data;
				etf_pkg::REG_JULIA_IM: jim_q   <= cfg_data;
				etf_pkg::REG_LIMIT:    limit_q <= cfg_data[etf_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign pr = sat_in(point.point_re);
	assign pi = sat_in(point.point_im);
	assign cr = (mode_q == etf_pkg::MODE_JULIA) ? sat_in(jre_q) : pr;
	assign ci = (mode_q == etf_pkg::MODE_JULIA) ? sat_in(jim_q) : pi;

	assign lim_ext  = LW'(limit_q);
	assign cmax_ext = LW'({NW{1'b1}});
	assign lim      = (lim_ext > cmax_ext) ? {NW{1'b1}} : lim_ext[NW-1:0];

	assign job_push = push && !job_full;
	assign job      = {ci, cr, pi, pr, lim};

endmodule

`default_nettype wire

>>> src/etf_core.sv
// Back part of the fractal iterator: runs z = z*z + c for one job at a time.
// Each iteration passes through magnitude, multiply and update phases; uses etf_pkg.
`default_nettype none

module etf_core #(
	parameter int COORD_WIDTH = etf_pkg::COORD_WIDTH_DEF,
	parameter int COUNT_WIDTH = etf_pkg::COUNT_WIDTH_DEF,
	parameter int JOB_W       = 4 * COORD_WIDTH + COUNT_WIDTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             job_empty,
	input  wire logic [JOB_W-1:0] job,
	output logic                  job_pop,
	input  wire logic             res_full,
	output logic                  res_push,
	output etf_pkg::res_t         res
);

	localparam int CW = COORD_WIDTH;
	localparam int NW = COUNT_WIDTH;
	localparam int FB = CW - etf_pkg::INT_BITS;
	localparam int MW = CW - 3;
	localparam int PW = 2 * MW;
	localparam int SW = (NW > etf_pkg::STEP_W) ? NW : etf_pkg::STEP_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MAG  = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_UPD  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]           st_q;
	logic signed [CW-1:0] zr_q;
	logic signed [CW-1:0] zi_q;
	logic signed [CW-1:0] cr_q;
	logic signed [CW-1:0] ci_q;
	logic [NW-1:0]        lim_q;
	logic [NW-1:0]        cnt_q;
	logic [MW-1:0]        ax_q;
	logic [MW-1:0]        ay_q;
	logic                 neg_q;
	logic [PW-1:0]        xx_q;
	logic [PW-1:0]        yy_q;
	logic [PW-1:0]        xy_q;
	etf_pkg::res_t        res_q;

	logic [CW-1:0]        ax;
	logic [CW-1:0]        ay;
	logic                 big;
	logic [PW:0]          mag2;
	logic signed [PW:0]   d;
	logic signed [PW:0]   sxy;
	logic signed [PW:0]   re_sh;
	logic signed [PW:0]   im_sh;
	logic signed [CW:0]   re_sum;
	logic signed [CW:0]   im_sum;
	logic [SW-1:0]        cnt_ext;

	function automatic logic signed [CW-1:0] sat_c(input logic signed [CW:0] v);
		if (v[CW] == v[CW-1]) begin
			return v[CW-1:0];
		end else if (v[CW]) begin
			return {1'b1, {(CW - 1){1'b0}}};
		end else begin
			return {1'b0, {(CW - 1){1'b1}}};
		end
	endfunction

	assign ax  = zr_q[CW-1] ? (~zr_q + 1'b1) : zr_q;
	assign ay  = zi_q[CW-1] ? (~zi_q + 1'b1) : zi_q;
	assign big = (|ax[CW-1:MW]) || (|ay[CW-1:MW]);

	assign mag2   = {1'b0, xx_q} + {1'b0, yy_q};
	assign d      = $signed({1'b0, xx_q}) - $signed({1'b0, yy_q});
	assign sxy    = neg_q ? -$signed({1'b0, xy_q}) : $signed({1'b0, xy_q});
	assign re_sh  = d >>> FB;
	assign im_sh  = sxy >>> (FB - 1);
	assign re_sum = $signed(re_sh[CW:0]) + $signed({cr_q[CW-1], cr_q});
	assign im_sum = $signed(im_sh[CW:0]) + $signed({ci_q[CW-1], ci_q});

	assign cnt_ext  = SW'(cnt_q);
	assign job_pop  = (st_q == S_IDLE) && !job_empty;
	assign res_push = (st_q == S_DONE) && !res_full;
	assign res      = res_q;

	always_ff @(posedge clk) begin
		if (st_q == S_MUL) begin
			xx_q <= PW'(ax_q) * PW'(ax_q);
			yy_q <= PW'(ay_q) * PW'(ay_q);
			xy_q <= PW'(ax_q) * PW'(ay_q);
		end
		if (st_q == S_MAG) begin
			ax_q  <= ax[MW-1:0];
			ay_q  <= ay[MW-1:0];
			neg_q <= zr_q[CW-1] ^ zi_q[CW-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_IDLE;
			zr_q  <= '0;
			zi_q  <= '0;
			cr_q  <= '0;
			ci_q  <= '0;
			lim_q <= '0;
			cnt_q <= '0;
			res_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (!job_empty) begin
						lim_q <= job[NW-1:0];
						zr_q  <= job[NW +: CW];
						zi_q  <= job[NW + CW +: CW];
						cr_q  <= job[NW + 2 * CW +: CW];
						ci_q  <= job[NW + 3 * CW +: CW];
						cnt_q <= '0;
						st_q  <= S_MAG;
					end
				end
				S_MAG: begin
					if (cnt_q == lim_q) begin
						res_q.color_index <= '0;
						res_q.escaped     <= 1'b0;
						res_q.step_count  <= cnt_ext[etf_pkg::STEP_W-1:0];
						st_q              <= S_DONE;
					end else if (big) begin
						res_q.color_index <= cnt_ext[etf_pkg::COLOR_W-1:0];
						res_q.escaped     <= 1'b1;
						res_q.step_count  <= cnt_ext[etf_pkg::STEP_W-1:0];
						st_q              <= S_DONE;
					end else begin
						st_q <= S_MUL;
					end
				end
				S_MUL: begin
					st_q <= S_UPD;
				end
				S_UPD: begin
					if (mag2[PW]) begin
						res_q.color_index <= cnt_ext[etf_pkg::COLOR_W-1:0];
						res_q.escaped     <= 1'b1;
						res_q.step_count  <= cnt_ext[etf_pkg::STEP_W-1:0];
						st_q              <= S_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						zr_q  <= sat_c(re_sum);
						zi_q  <= sat_c(im_sum);
						st_q  <= S_MAG;
					end
				end
				S_DONE: begin
					if (!res_full) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> src/escape_time_fractal_iterator.sv
// Top level of the escape-time fractal iterator (Mandelbrot and Julia modes).
// Instantiates etf_front, two etf_fifo queues and etf_core; uses etf_pkg.
//
//   channel   ports                             transfer when
//   input     push, full, point                 push && !full
//   result    empty, pop, result                pop && !empty
//   config    cfg_wr_en, cfg_index, cfg_data    cfg_wr_en
//
// etf_core loads a point in its idle state, iterates through its magnitude, multiply and
// update states, ends in the magnitude or update state and hands the result off when done.
// Up to two points wait in the job queue and two results in the result queue.
// Reset clears the queues, the iterator and the configuration to its defaults.
// A full result queue holds the iterator; a stalled iterator only fills the job queue.
`default_nettype none

module escape_time_fractal_iterator #(
	parameter int COORD_WIDTH = etf_pkg::COORD_WIDTH_DEF,
	parameter int COUNT_WIDTH = etf_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire etf_pkg::point_t               point,
	output logic                               empty,
	input  wire logic                          pop,
	output etf_pkg::res_t                      result,
	input  wire logic                          cfg_wr_en,
	input  wire logic [etf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [etf_pkg::CFG_DAT_W-1:0] cfg_data
);

	localparam int JOB_W = 4 * COORD_WIDTH + COUNT_WIDTH;
	localparam int RES_W = $bits(etf_pkg::res_t);

	logic             job_push;
	logic [JOB_W-1:0] job_in;
	logic             job_empty;
	logic             job_pop;
	logic [JOB_W-1:0] job_out;
	logic             res_full;
	logic             res_push;
	etf_pkg::res_t    res_in;
	logic [RES_W-1:0] res_out;

	etf_front #(
		.COORD_WIDTH(COORD_WIDTH),
		.COUNT_WIDTH(COUNT_WIDTH),
		.JOB_W      (JOB_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.job_full (full),
		.point    (point),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.job_push (job_push),
		.job      (job_in)
	);

	etf_fifo #(
		.WIDTH(JOB_W),
		.DEPTH(etf_pkg::JOB_DEPTH)
	) u_job_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (job_push),
		.wdata (job_in),
		.full  (full),
		.pop   (job_pop),
		.rdata (job_out),
		.empty (job_empty)
	);

	etf_core #(
		.COORD_WIDTH(COORD_WIDTH),
		.COUNT_WIDTH(COUNT_WIDTH),
		.JOB_W      (JOB_W)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_empty(job_empty),
		.job      (job_out),
		.job_pop  (job_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	etf_fifo #(
		.WIDTH(RES_W),
		.DEPTH(etf_pkg::RES_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_out),
		.empty (empty)
	);

	assign result = res_out;

endmodule

`default_nettype wire
